// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define LBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another in the next cycle, outside reset.
`define LBC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/lbc_pkg.sv
package lbc_pkg;

  localparam int LBC_NUM_LEDS = 3;

  localparam int LED_W  = 3;
  localparam int VAL_W  = 16;
  localparam int LVL_W  = 8;
  localparam int DUTY_W = 10;
  localparam int PH_W   = 5;
  localparam int TOT_W  = 4;
  localparam int CFG_AW = 2;

  localparam logic [VAL_W-1:0] ON_MS_RESET    = 16'd100;
  localparam logic [VAL_W-1:0] OFF_MS_RESET   = 16'd700;
  localparam logic [VAL_W-1:0] PAUSE_MS_RESET = 16'd2000;
  localparam logic [7:0]       MASK_RESET     = 8'd6;
  localparam logic [LVL_W-1:0] LEVEL_FULL     = 8'd255;
  localparam logic [VAL_W-1:0] MODE_ON_MIN    = 16'd10;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_MODE     = 2'd1;
  localparam logic [1:0] REQ_LEVEL    = 2'd2;
  localparam logic [1:0] REQ_OVERRIDE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LED = 2'd1;
  localparam logic [1:0] ST_BAD_VAL = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_ON_MS    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_OFF_MS   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_PAUSE_MS = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_PWM_MASK = 2'd3;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_t;

  typedef struct packed {
    logic             load;
    logic             tick_step;
    logic             cmd_step;
    logic             last;
    logic [LED_W-1:0] led_sel;
  } lbc_cmd_t;

  typedef struct packed {
    logic slot_free;
  } lbc_stat_t;

endpackage

// File: sv/lbc_ctrl.sv
module lbc_ctrl
  import lbc_pkg::*;
#(
  parameter int NUM_LEDS = LBC_NUM_LEDS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_is_tick,
  output logic      in_tready,
  input  lbc_stat_t stat,
  output lbc_cmd_t  cmd
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_CMD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_end;

  assign cnt_end = (cnt_r == IDX_W'(NUM_LEDS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.tick_step = 1'b0;
    cmd.cmd_step  = 1'b0;
    cmd.last      = 1'b0;
    cmd.led_sel   = LED_W'(cnt_r);
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = in_is_tick ? S_TICK : S_CMD;
        end
      end
      S_TICK: begin
        if (stat.slot_free) begin
          cmd.tick_step = 1'b1;
          cmd.last      = cnt_end;
          if (cnt_end) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_CMD: begin
        if (stat.slot_free) begin
          cmd.cmd_step = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`include "assert_macros.svh"

  `LBC_ASSERT(a_step_excl, !(cmd.tick_step && cmd.cmd_step), "tick and command step together")
  `LBC_ASSERT_NEXT(a_last_idle, cmd.tick_step && cmd.last, state_r == S_IDLE, "no idle after tick")
  `LBC_ASSERT_NEXT(a_load_busy, cmd.load, (state_r == S_TICK) || (state_r == S_CMD), "load lost")

endmodule

// File: sv/lbc_datapath.sv
module lbc_datapath
  import lbc_pkg::*;
#(
  parameter int NUM_LEDS = LBC_NUM_LEDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [VAL_W-1:0]  cfg_wdata,
  input  logic [1:0]        in_req,
  input  logic [LED_W-1:0]  in_idx,
  input  logic [VAL_W-1:0]  in_val,
  input  lbc_cmd_t          cmd,
  output lbc_stat_t         stat,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [LED_W-1:0]  out_led,
  output logic              out_lit,
  output logic              out_full_on,
  output logic [DUTY_W-1:0] out_pwm_duty,
  output logic [1:0]        out_status,
  output logic              out_last
);

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  logic [VAL_W-1:0]    on_ms_r, off_ms_r, pause_ms_r;
  logic [NUM_LEDS-1:0] mask_r;

  logic [1:0]       req_r;
  logic [LED_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;

  mode_t            mode_r  [NUM_LEDS];
  logic [TOT_W-1:0] total_r [NUM_LEDS];
  logic [PH_W-1:0]  phase_r [NUM_LEDS];
  logic [VAL_W-1:0] cd_r    [NUM_LEDS];
  logic [LVL_W-1:0] level_r [NUM_LEDS];
  logic [LVL_W-1:0] ovr_r   [NUM_LEDS];

  logic              valid_r;
  logic [LED_W-1:0]  led_r;
  logic              lit_r, full_r, last_r;
  logic [DUTY_W-1:0] duty_r;
  logic [1:0]        status_r;

  logic [IDX_W-1:0] addr;
  logic             bad_led, bad_val, wr_en;
  mode_t            cur_mode, w_mode;
  logic [TOT_W-1:0] w_total;
  logic [PH_W-1:0]  cur_phase, w_phase;
  logic [VAL_W-1:0] dec_cd, w_cd;
  logic [LVL_W-1:0] lvl_max, lvl_c, w_level, w_ovr;
  logic             t_lit, t_full;
  logic [DUTY_W-1:0] t_duty;
  logic [1:0]       c_status;

  assign stat.slot_free = !valid_r || out_tready;
  assign bad_led = ({1'b0, idx_r} >= (LED_W + 1)'(NUM_LEDS));
  assign bad_val = (val_r > VAL_W'(LEVEL_FULL));

  always_comb begin
    addr      = cmd.cmd_step ? idx_r[IDX_W-1:0] : cmd.led_sel[IDX_W-1:0];
    cur_mode  = mode_r[addr];
    cur_phase = phase_r[addr];
    w_mode    = cur_mode;
    w_total   = total_r[addr];
    w_phase   = cur_phase;
    w_cd      = cd_r[addr];
    w_level   = level_r[addr];
    w_ovr     = ovr_r[addr];
    wr_en     = 1'b0;
    c_status  = ST_OK;

    lvl_max = (level_r[addr] < ovr_r[addr]) ? ovr_r[addr] : level_r[addr];
    lvl_c   = (lvl_max == '0) ? LVL_W'(1) : lvl_max;
    t_lit   = (cur_mode == MODE_ON) || ((cur_mode == MODE_BLINK) && cur_phase[0]);
    t_full  = t_lit && ((lvl_c == LEVEL_FULL) || !mask_r[addr]);
    t_duty  = (t_lit && !t_full) ? {~lvl_c, 2'b00} : '0;
    dec_cd  = (cd_r[addr] != '0) ? cd_r[addr] - 1'b1 : '0;

    if (cmd.tick_step) begin
      wr_en = 1'b1;
      w_cd  = dec_cd;
      if (dec_cd == '0) begin
        if (cur_mode == MODE_BLINK) begin
          w_phase = cur_phase - 1'b1;
          if (w_phase == '0) begin
            w_mode = MODE_PAUSE;
            w_cd   = pause_ms_r;
          end else if (w_phase[0]) begin
            w_cd = on_ms_r;
          end else begin
            w_cd = off_ms_r;
          end
        end else if (cur_mode == MODE_PAUSE) begin
          w_phase = {total_r[addr], 1'b0} - 1'b1;
          w_mode  = MODE_BLINK;
          w_cd    = on_ms_r;
        end
      end
    end else if (cmd.cmd_step) begin
      priority if (bad_led) begin
        c_status = ST_BAD_LED;
      end else if (req_r == REQ_MODE) begin
        wr_en = 1'b1;
        w_cd  = '0;
        if (val_r == '0) begin
          w_mode = MODE_OFF;
        end else if (val_r >= MODE_ON_MIN) begin
          w_mode = MODE_ON;
        end else begin
          w_mode  = MODE_BLINK;
          w_total = val_r[TOT_W-1:0];
          w_phase = {val_r[TOT_W-1:0], 1'b0} - 1'b1;
          w_cd    = on_ms_r;
        end
      end else if (bad_val) begin
        c_status = ST_BAD_VAL;
      end else if (req_r == REQ_LEVEL) begin
        wr_en   = 1'b1;
        w_level = val_r[LVL_W-1:0];
      end else begin
        wr_en = 1'b1;
        w_ovr = val_r[LVL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ms_r    <= ON_MS_RESET;
      off_ms_r   <= OFF_MS_RESET;
      pause_ms_r <= PAUSE_MS_RESET;
      mask_r     <= MASK_RESET[NUM_LEDS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ON_MS:    on_ms_r    <= cfg_wdata;
        CFG_OFF_MS:   off_ms_r   <= cfg_wdata;
        CFG_PAUSE_MS: pause_ms_r <= cfg_wdata;
        CFG_PWM_MASK: mask_r     <= cfg_wdata[NUM_LEDS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      idx_r <= in_idx;
      val_r <= in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i]  <= MODE_OFF;
        total_r[i] <= '0;
        phase_r[i] <= '0;
        cd_r[i]    <= '0;
        level_r[i] <= LEVEL_FULL;
        ovr_r[i]   <= '0;
      end
    end else if (wr_en) begin
      mode_r[addr]  <= w_mode;
      total_r[addr] <= w_total;
      phase_r[addr] <= w_phase;
      cd_r[addr]    <= w_cd;
      level_r[addr] <= w_level;
      ovr_r[addr]   <= w_ovr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.tick_step || cmd.cmd_step) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step) begin
      led_r    <= cmd.led_sel;
      lit_r    <= t_lit;
      full_r   <= t_full;
      duty_r   <= t_duty;
      status_r <= ST_OK;
      last_r   <= cmd.last;
    end else if (cmd.cmd_step) begin
      led_r    <= idx_r;
      lit_r    <= 1'b0;
      full_r   <= 1'b0;
      duty_r   <= '0;
      status_r <= c_status;
      last_r   <= 1'b1;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_led      = led_r;
  assign out_lit      = lit_r;
  assign out_full_on  = full_r;
  assign out_pwm_duty = duty_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

`include "assert_macros.svh"

  `LBC_ASSERT(a_step_slot, !(cmd.tick_step || cmd.cmd_step) || stat.slot_free, "result overrun")
  `LBC_ASSERT(a_duty_dark, !(valid_r && !lit_r) || (duty_r == '0), "duty on dark LED")
  `LBC_ASSERT(a_full_lit, !(valid_r && full_r) || lit_r, "full on while dark")

endmodule

// File: sv/led_blink_code_controller.sv
// Status LED blink-code controller.
// The input stream carries one request per transfer: in_tuser holds the request
// type (tick, set mode, set intensity, set override), in_tdata the LED index and
// the command value. A tick produces one result transfer per LED, in LED order,
// with out_tlast on the last one; a command produces a single result with
// out_tlast set and its status in out_tuser.
// The input is taken into the request register, then a sequencer visits the LED
// state entries one at a time and writes one result per step into the output
// register, stepping only while that register is free. The first result is valid
// after the sequencer's first step. A new request is accepted only after the
// last result of the previous one has entered the output register.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds until it has been taken.
// The cfg port writes timing registers and the PWM mask; it is
// meant for use while no request is in flight.
// A synchronous reset restores the register defaults, turns every LED off with
// full level and no override, and empties the output register.
module led_blink_code_controller
  import lbc_pkg::*;
#(
  parameter int NUM_LEDS = LBC_NUM_LEDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [VAL_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // led_index[2:0], cmd_value[18:3], zero pad
  input  logic [1:0]        in_tuser,   // req_type[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // out_led[2:0], lit[3], full_on[4], pwm_duty[14:5]
  output logic [1:0]        out_tuser,  // status[1:0]
  output logic              out_tlast
);

  lbc_cmd_t          cmd;
  lbc_stat_t         stat;
  logic [LED_W-1:0]  res_led;
  logic              res_lit, res_full;
  logic [DUTY_W-1:0] res_duty;

  lbc_ctrl #(
    .NUM_LEDS(NUM_LEDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_is_tick(in_tuser == REQ_TICK),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbc_datapath #(
    .NUM_LEDS(NUM_LEDS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_req      (in_tuser),
    .in_idx      (in_tdata[2:0]),
    .in_val      (in_tdata[18:3]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_led     (res_led),
    .out_lit     (res_lit),
    .out_full_on (res_full),
    .out_pwm_duty(res_duty),
    .out_status  (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, res_duty, res_full, res_lit, res_led};

endmodule

// File: tb/sv/tb_led_blink_code_controller.sv
module tb_led_blink_code_controller;
  import lbc_pkg::*;

  localparam int NLEDS = LBC_NUM_LEDS;
  localparam int SEGMENTS = 5;
  localparam int ITEMS_PER_SEGMENT = 55;

  typedef struct {
    logic [1:0]       req;
    logic [LED_W-1:0] led;
    logic [VAL_W-1:0] value;
  } led_request_t;

  typedef struct {
    logic [LED_W-1:0]  led;
    logic              lit;
    logic              full_on;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        status;
    logic              last;
  } led_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [VAL_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  led_blink_code_controller #(.NUM_LEDS(NLEDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timing registers and the per-LED state.
  logic [VAL_W-1:0] on_ms = ON_MS_RESET;
  logic [VAL_W-1:0] off_ms = OFF_MS_RESET;
  logic [VAL_W-1:0] pause_ms = PAUSE_MS_RESET;
  logic [7:0]       pwm_mask = MASK_RESET;

  mode_t            led_mode[NLEDS];
  logic [TOT_W-1:0] blink_total[NLEDS];
  logic [PH_W-1:0]  phase_left[NLEDS];
  logic [VAL_W-1:0] countdown[NLEDS];
  logic [LVL_W-1:0] level[NLEDS];
  logic [LVL_W-1:0] level_override[NLEDS];

  led_request_t request_backlog[$];
  led_report_t  expected_reports[$];
  led_request_t on_bus;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_done = 0;
  int reports_checked = 0;
  int mismatches = 0;

  initial begin
    for (int i = 0; i < NLEDS; i++) begin
      led_mode[i] = MODE_OFF;
      blink_total[i] = '0;
      phase_left[i] = '0;
      countdown[i] = '0;
      level[i] = LEVEL_FULL;
      level_override[i] = '0;
    end
  end

  // Updates the LED state for one request and queues the reports it should produce.
  task automatic apply_request(input led_request_t r);
    led_report_t rep;
    logic [LVL_W-1:0] c;
    if (r.req == REQ_TICK) begin
      for (int i = 0; i < NLEDS; i++) begin
        rep = '{default: '0};
        rep.led = LED_W'(i);
        rep.last = (i == NLEDS - 1);
        if (led_mode[i] == MODE_ON || (led_mode[i] == MODE_BLINK && phase_left[i][0])) begin
          rep.lit = 1'b1;
          c = level[i];
          if (c < level_override[i]) c = level_override[i];
          if (c == 0) c = 1;
          if (c == LEVEL_FULL || !pwm_mask[i]) rep.full_on = 1'b1;
          else rep.duty = DUTY_W'(4 * (255 - int'(c)));
        end
        expected_reports.push_back(rep);
        if (countdown[i] != 0) countdown[i] = countdown[i] - 1'b1;
        if (countdown[i] == 0) begin
          if (led_mode[i] == MODE_BLINK) begin
            phase_left[i] = phase_left[i] - 1'b1;
            if (phase_left[i] == 0) begin
              led_mode[i] = MODE_PAUSE;
              countdown[i] = pause_ms;
            end else if (phase_left[i][0]) begin
              countdown[i] = on_ms;
            end else begin
              countdown[i] = off_ms;
            end
          end else if (led_mode[i] == MODE_PAUSE) begin
            phase_left[i] = PH_W'(2 * int'(blink_total[i]) - 1);
            led_mode[i] = MODE_BLINK;
            countdown[i] = on_ms;
          end
        end
      end
    end else begin
      rep = '{default: '0};
      rep.led = r.led;
      rep.last = 1'b1;
      rep.status = ST_OK;
      if (r.led >= NLEDS) begin
        rep.status = ST_BAD_LED;
      end else if (r.req == REQ_MODE) begin
        countdown[r.led] = '0;
        if (r.value == 0) begin
          led_mode[r.led] = MODE_OFF;
        end else if (r.value >= MODE_ON_MIN) begin
          led_mode[r.led] = MODE_ON;
        end else begin
          led_mode[r.led] = MODE_BLINK;
          blink_total[r.led] = r.value[TOT_W-1:0];
          phase_left[r.led] = PH_W'(2 * int'(r.value) - 1);
          countdown[r.led] = on_ms;
        end
      end else if (r.value > 255) begin
        rep.status = ST_BAD_VAL;
      end else if (r.req == REQ_LEVEL) begin
        level[r.led] = r.value[LVL_W-1:0];
      end else begin
        level_override[r.led] = r.value[LVL_W-1:0];
      end
      expected_reports.push_back(rep);
    end
  endtask

  task automatic check_report();
    led_report_t exp_rep;
    if (expected_reports.size() == 0) begin
      $error("unexpected report transfer: out_tdata %h out_tuser %0d out_tlast %0d",
             out_tdata, out_tuser, out_tlast);
      mismatches++;
    end else begin
      exp_rep = expected_reports.pop_front();
      reports_checked++;
      if (out_tdata[2:0] !== exp_rep.led) begin
        $error("out_led expected %0d actual %0d", exp_rep.led, out_tdata[2:0]);
        mismatches++;
      end
      if (out_tdata[3] !== exp_rep.lit) begin
        $error("lit expected %0d actual %0d", exp_rep.lit, out_tdata[3]);
        mismatches++;
      end
      if (out_tdata[4] !== exp_rep.full_on) begin
        $error("full_on expected %0d actual %0d", exp_rep.full_on, out_tdata[4]);
        mismatches++;
      end
      if (out_tdata[14:5] !== exp_rep.duty) begin
        $error("pwm_duty expected %0d actual %0d", exp_rep.duty, out_tdata[14:5]);
        mismatches++;
      end
      if (out_tuser !== exp_rep.status) begin
        $error("status expected %0d actual %0d", exp_rep.status, out_tuser);
        mismatches++;
      end
      if (out_tlast !== exp_rep.last) begin
        $error("last expected %0d actual %0d", exp_rep.last, out_tlast);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(on_bus);
        requests_done++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = request_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= on_bus.req;
          in_tdata <= {5'b0, on_bus.value, on_bus.led};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_report();
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void queue_request(input logic [1:0] req, input int led, input int value);
    led_request_t r;
    r.req = req;
    r.led = LED_W'(led);
    r.value = VAL_W'(value);
    request_backlog.push_back(r);
  endfunction

  function automatic led_request_t random_request();
    led_request_t r;
    int pick;
    pick = $urandom_range(99);
    r.led = ($urandom_range(9) == 0) ? LED_W'($urandom_range(7, NLEDS))
                                     : LED_W'($urandom_range(NLEDS - 1, 0));
    r.value = VAL_W'($urandom);
    if (pick < 55) begin
      r.req = REQ_TICK;
    end else if (pick < 70) begin
      r.req = REQ_MODE;
      pick = $urandom_range(99);
      if (pick < 15) r.value = '0;
      else if (pick < 70) r.value = VAL_W'($urandom_range(9, 1));
      else r.value = VAL_W'($urandom_range(65535, 10));
    end else begin
      r.req = (pick < 85) ? REQ_LEVEL : REQ_OVERRIDE;
      if ($urandom_range(99) < 85) r.value = VAL_W'($urandom_range(255, 0));
      else r.value = VAL_W'($urandom_range(65535, 256));
    end
    return r;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_tvalid || expected_reports.size() != 0);
  endtask

  task automatic program_timing(input int on_val, input int off_val, input int pause_val,
                                input int mask_val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_ON_MS;
    cfg_wdata <= VAL_W'(on_val);
    @(posedge clk);
    cfg_addr <= CFG_OFF_MS;
    cfg_wdata <= VAL_W'(off_val);
    @(posedge clk);
    cfg_addr <= CFG_PAUSE_MS;
    cfg_wdata <= VAL_W'(pause_val);
    @(posedge clk);
    cfg_addr <= CFG_PWM_MASK;
    cfg_wdata <= VAL_W'(mask_val & 8'hFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    on_ms = VAL_W'(on_val);
    off_ms = VAL_W'(off_val);
    pause_ms = VAL_W'(pause_val);
    pwm_mask = 8'(mask_val);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_stall_pct = 86;

    // Directed requests under the reset timing values.
    queue_request(REQ_TICK, 0, 0);
    queue_request(REQ_MODE, 0, 10);
    queue_request(REQ_TICK, 7, 16'hFFFF);
    queue_request(REQ_LEVEL, 1, 0);
    queue_request(REQ_MODE, 1, 16'hFFFF);
    queue_request(REQ_TICK, 3, 16'h5A5A);
    queue_request(REQ_OVERRIDE, 1, 255);
    queue_request(REQ_LEVEL, 2, 128);
    queue_request(REQ_OVERRIDE, 2, 200);
    queue_request(REQ_MODE, 2, 1);
    queue_request(REQ_TICK, 0, 0);
    queue_request(REQ_LEVEL, 0, 256);
    queue_request(REQ_OVERRIDE, 0, 16'hFFFF);
    queue_request(REQ_LEVEL, 0, 0);
    queue_request(REQ_OVERRIDE, 0, 0);
    queue_request(REQ_MODE, 3, 1);
    queue_request(REQ_LEVEL, 7, 300);
    queue_request(REQ_OVERRIDE, 4, 0);
    queue_request(REQ_MODE, 5, 0);
    queue_request(REQ_LEVEL, 6, 16'hAAAA);
    queue_request(REQ_TICK, 0, 0);
    queue_request(REQ_MODE, 1, 9);
    queue_request(REQ_MODE, 0, 0);
    queue_request(REQ_TICK, 0, 0);
    wait_drained();

    for (int seg = 1; seg <= SEGMENTS; seg++) begin
      case (seg)
        1: program_timing(1, 1, 1, 8'hFF);
        2: program_timing(0, 0, 0, 8'h00);
        3: program_timing(2, 65535, 1, 8'hAA);
        4: program_timing(65535, 3, 65535, 8'h55);
        default: program_timing($urandom_range(4, 1), $urandom_range(4, 0),
                                 $urandom_range(6, 1), $urandom_range(255, 0));
      endcase
      if (seg >= 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (seg >= 2) begin
        send_idle_pct = 86;
        recv_stall_pct = 17;
      end
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) request_backlog.push_back(random_request());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d LED requests over %0d timing settings and checked %0d reports.",
             requests_done, SEGMENTS + 1, reports_checked);
    $display("Both stream sides were throttled in turn, then run at full rate.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
